### design/fcpv_pkg.sv
// Shared constants for the four-channel PI valve controller.
// Holds stream widths, register indexes and parameter defaults; no dependencies.
package fcpv_pkg;

	// stream payload widths
	localparam int CH_W        = 2;
	localparam int HEIGHT_W    = 16;
	localparam int GAIN_W      = 24;
	localparam int DUTY_W      = 14;
	localparam int DRIVE_W     = 18;
	localparam int ERR_W       = 17;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 48;
	localparam int CFG_INDEX_W = 3;

	// gain register file
	localparam int                     NUM_GAIN_CH = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_KP0     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KITS0   = 3'd4;

	// Q16 unity and duty ceiling
	localparam int ONE_Q16  = 65536;
	localparam int DUTY_TOP = 16383;

	// parameter defaults
	localparam int CHANNELS_DEF  = 4;
	localparam int DEAD_ZONE_DEF = 10;
	localparam int PWM_MIN_DEF   = 3000;
	localparam int PWM_MAX_DEF   = 10000;

endpackage

### design/four_channel_pi_valve_controller.sv
// Four-channel velocity-form PI valve controller, top level.
// Each item is taken in IDLE and steps through LOAD, P, I, SUM, CLAMP, DUTY and FIN;
// a single shared 25x18 multiplier is used for the P term, the I term and the duty
// scaling in turn under a small sequencer, and no new item is taken until FIN ends.
// Reset (arst_n low, asynchronous) clears gains, per-channel error and drive.
// Depends on fcpv_pkg.
module four_channel_pi_valve_controller #(
	parameter int CHANNELS  = fcpv_pkg::CHANNELS_DEF,
	parameter int DEAD_ZONE = fcpv_pkg::DEAD_ZONE_DEF,
	parameter int PWM_MIN   = fcpv_pkg::PWM_MIN_DEF,
	parameter int PWM_MAX   = fcpv_pkg::PWM_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [fcpv_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fcpv_pkg::GAIN_W-1:0]         cfg_data,
	// input items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fcpv_pkg::S_TDATA_W-1:0]      s_tdata,  // set_height[15:0], actual_height[31:16]
	input  logic [fcpv_pkg::CH_W-1:0]           s_tuser,  // channel[1:0]
	// result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fcpv_pkg::M_TDATA_W-1:0]      m_tdata,  // raise_pwm[13:0], sink_pwm[27:14],
	                                                      // drive[45:28], zero[47:46]
	output logic [fcpv_pkg::CH_W-1:0]           m_tuser   // out_channel[1:0]
);
	import fcpv_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SPAN  = PWM_MAX - PWM_MIN;
	localparam bit SPAN_NEG = (SPAN < 0);
	localparam logic signed [24:0] SPAN_ABS = 25'((SPAN < 0) ? -SPAN : SPAN);
	localparam logic signed [19:0] PMIN     = 20'(PWM_MIN);
	localparam logic signed [19:0] DTOP     = 20'(DUTY_TOP);
	localparam logic signed [ERR_W-1:0] DZ  = ERR_W'(DEAD_ZONE);
	localparam logic signed [43:0] POS_ONE  = 44'(ONE_Q16);
	localparam logic signed [43:0] NEG_ONE  = -44'(ONE_Q16);

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_P, S_I, S_SUM, S_CLAMP, S_DUTY, S_FIN
	} state_t;

	state_t state_q;

	logic [GAIN_W-1:0] kp_q   [NUM_GAIN_CH];
	logic [GAIN_W-1:0] kits_q [NUM_GAIN_CH];

	logic signed [ERR_W-1:0]   last_error_q [CHANNELS];
	logic signed [DRIVE_W-1:0] last_drive_q [CHANNELS];

	logic [CH_W-1:0]           ch_q;
	logic [HEIGHT_W-1:0]       set_q;
	logic [HEIGHT_W-1:0]       act_q;
	logic                      bad_q;
	logic signed [ERR_W-1:0]   e_q;
	logic signed [DRIVE_W-1:0] diff_q;
	logic signed [42:0]        prod_q;
	logic signed [43:0]        acc_q;
	logic signed [DRIVE_W-1:0] y_q;

	logic                      m_tvalid_q;
	logic [DUTY_W-1:0]         raise_q;
	logic [DUTY_W-1:0]         sink_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic [CH_W-1:0]           out_ch_q;

	logic [IDX_W-1:0]          idx;
	logic signed [ERR_W-1:0]   e_raw;
	logic signed [ERR_W-1:0]   e_dz;
	logic signed [24:0]        mul_a;
	logic signed [DRIVE_W-1:0] mul_b;
	logic signed [42:0]        mul_p;
	logic signed [DRIVE_W-1:0] y_mag;
	logic signed [DRIVE_W-1:0] y_clamp;
	logic [16:0]               q_duty;
	logic signed [19:0]        d_sum;
	logic [DUTY_W-1:0]         d_sat;

	assign idx   = IDX_W'(ch_q);
	assign e_raw = $signed({1'b0, set_q}) - $signed({1'b0, act_q});
	assign e_dz  = (e_raw < DZ && e_raw > -DZ) ? '0 : e_raw;
	assign y_mag = y_q[DRIVE_W-1] ? -y_q : y_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_P: begin
				mul_a = $signed({1'b0, kp_q[ch_q]});
				mul_b = diff_q;
			end
			S_I: begin
				mul_a = $signed({1'b0, kits_q[ch_q]});
				mul_b = DRIVE_W'(e_q);
			end
			S_DUTY: begin
				mul_a = SPAN_ABS;
				mul_b = y_mag;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = 43'(mul_a) * 43'(mul_b);

	always_comb begin
		if (acc_q >= POS_ONE) begin
			y_clamp = DRIVE_W'(ONE_Q16);
		end else if (acc_q <= NEG_ONE) begin
			y_clamp = -DRIVE_W'(ONE_Q16);
		end else begin
			y_clamp = acc_q[DRIVE_W-1:0];
		end
	end

	// duty = PWM_MIN +/- |span| * |y| / 65536, truncated toward zero, saturated
	assign q_duty = prod_q[32:16];
	assign d_sum  = SPAN_NEG ? (PMIN - $signed({3'b000, q_duty}))
	                         : (PMIN + $signed({3'b000, q_duty}));
	always_comb begin
		if (d_sum < 0) begin
			d_sat = '0;
		end else if (d_sum > DTOP) begin
			d_sat = DUTY_W'(DUTY_TOP);
		end else begin
			d_sat = d_sum[DUTY_W-1:0];
		end
	end

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GAIN_CH; i++) begin
				kp_q[i]   <= '0;
				kits_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index >= REG_KITS0) begin
				kits_q[cfg_index[CH_W-1:0]] <= cfg_data;
			end else if (cfg_index >= REG_KP0) begin
				kp_q[cfg_index[CH_W-1:0]] <= cfg_data;
			end
		end
	end

	// sequencer, per-channel state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_error_q[i] <= '0;
				last_drive_q[i] <= '0;
			end
		end else begin
			// S_FIN reloads the output register itself
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						ch_q    <= s_tuser;
						set_q   <= s_tdata[HEIGHT_W-1:0];
						act_q   <= s_tdata[2*HEIGHT_W-1:HEIGHT_W];
						bad_q   <= ({3'b000, s_tuser} >= 5'(CHANNELS));
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					e_q     <= e_dz;
					diff_q  <= DRIVE_W'(e_dz) - DRIVE_W'(last_error_q[idx]);
					state_q <= S_P;
				end
				S_P: begin
					prod_q  <= mul_p;
					state_q <= S_I;
				end
				S_I: begin
					acc_q   <= 44'(last_drive_q[idx]) + 44'(prod_q);
					prod_q  <= mul_p;
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= acc_q + 44'(prod_q);
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					y_q <= bad_q ? '0 : y_clamp;
					if (!bad_q) begin
						last_error_q[idx] <= e_q;
						last_drive_q[idx] <= y_clamp;
					end
					state_q <= S_DUTY;
				end
				S_DUTY: begin
					prod_q  <= mul_p;
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						out_ch_q   <= ch_q;
						drive_q    <= y_q;
						raise_q    <= (bad_q || y_q[DRIVE_W-1]) ? '0 : d_sat;
						sink_q     <= (!bad_q && y_q[DRIVE_W-1]) ? d_sat : '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_ch_q;
	assign m_tdata  = {2'b00, drive_q, sink_q, raise_q};

endmodule
